[hw/rtl/point_rotate_about_pivot_core_defines.svh]
// Assertion macros shared by the point rotation checker
`ifndef POINT_ROTATE_ABOUT_PIVOT_CORE_DEFINES_SVH
`define POINT_ROTATE_ABOUT_PIVOT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PRAP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PRAP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/prap_pkg.sv]
// Shared constants, types and the CORDIC angle table for the point rotation core
`timescale 1ns / 1ps

package prap_pkg;

  localparam int COORD_W       = 32;
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TURN_W        = 32;
  localparam int TRIG_W        = 32;
  localparam int TRIG_FRAC     = 30;
  localparam int DIFF_W        = COORD_W + 1;

  localparam logic signed [TRIG_W-1:0] INV_GAIN = 32'sd652032874;
  localparam logic signed [TURN_W-1:0] QUARTER  = {2'b01, {(TURN_W-2){1'b0}}};

  // Angle reduction: 360 degrees = 45 * 8, so the period is 45 << (FRAC_BITS + 3)
  localparam int     DEG_DIV    = 45;
  localparam int     DEG_SH     = 3;
  localparam int     LO_W       = FRAC_BITS + DEG_SH;
  localparam longint PERIOD     = longint'(DEG_DIV) << LO_W;
  localparam longint HALF_RANGE = longint'(1) << (COORD_W - 1);
  localparam longint ANG_ADD    = PERIOD - (HALF_RANGE % PERIOD);
  localparam int     U_W        = ((COORD_W > $clog2(PERIOD)) ? COORD_W : $clog2(PERIOD)) + 1;
  localparam int     H_W        = U_W - LO_W;
  localparam int     HQ_K       = H_W + 6;
  localparam longint HQ_M       = (longint'(1) << HQ_K) / DEG_DIV;
  localparam int     HQ_M_W     = HQ_K - 5;
  localparam int     HQ_Q_W     = H_W - 5;
  localparam int     HQ_P_W     = H_W + HQ_M_W;
  localparam int     HM_W       = 6;
  localparam int     R_W        = HM_W + LO_W;

  // Turn fraction: t = TQ * r + floor(TR * r / 45)
  localparam int     TSH        = TURN_W - FRAC_BITS - DEG_SH;
  localparam longint TQ         = (longint'(1) << TSH) / DEG_DIV;
  localparam longint TR         = (longint'(1) << TSH) % DEG_DIV;
  localparam int     TP_W       = R_W + TSH;
  localparam int     V_W        = R_W + 6;
  localparam int     RQ_K       = V_W + 6;
  localparam longint RQ_M       = (longint'(1) << RQ_K) / DEG_DIV;
  localparam int     RQ_M_W     = RQ_K - 5;
  localparam int     RQ_Q_W     = V_W - 5;
  localparam int     RQ_P_W     = V_W + RQ_M_W;

  // Final products and rounding
  localparam int PROD_W = DIFF_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - TRIG_FRAC + 1;
  localparam logic signed [SUM_W-1:0] RND_HALF =
    {{(SUM_W-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic flip;
  } prap_ctl_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } prap_geo_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic                      sat;
  } prap_res_t;

  // atan(2^-idx) as a fraction of a full turn, 2^32 per turn
  function automatic logic signed [TURN_W-1:0] atan_turn(input logic [4:0] idx);
    logic signed [TURN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41722;
      5'd15:   v = 32'sd20861;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2608;
      5'd19:   v = 32'sd1304;
      5'd20:   v = 32'sd652;
      5'd21:   v = 32'sd326;
      5'd22:   v = 32'sd163;
      5'd23:   v = 32'sd81;
      5'd24:   v = 32'sd41;
      5'd25:   v = 32'sd20;
      5'd26:   v = 32'sd10;
      5'd27:   v = 32'sd5;
      5'd28:   v = 32'sd3;
      5'd29:   v = 32'sd1;
      5'd30:   v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/point_rotate_about_pivot_core.sv]
// 27 register stages from input transfer to out_valid (7 reduction, 16 CORDIC, 3 mix,
// 1 output), the first of them loaded at the transfer edge.
// Throughput: one point per cycle; every stage holds while the one-entry skid slot is full.
// in_stall is the skid slot's fill bit: it rises only when a result arrives while out_stall
// holds a result in the output register, and falls once the output side takes that result.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module point_rotate_about_pivot_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [prap_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [prap_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [prap_pkg::COORD_W-1:0] in_pivot_x,
  input  logic signed [prap_pkg::COORD_W-1:0] in_pivot_y,
  input  logic signed [prap_pkg::COORD_W-1:0] in_angle_deg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [prap_pkg::COORD_W-1:0] out_rotated_x,
  output logic signed [prap_pkg::COORD_W-1:0] out_rotated_y,
  output logic                                out_saturated
);

  logic                               en;
  prap_pkg::prap_ctl_t                fr_ctl, co_ctl;
  prap_pkg::prap_geo_t                fr_geo, co_geo;
  logic signed [prap_pkg::TURN_W-1:0] fr_z;
  logic signed [prap_pkg::TRIG_W-1:0] co_cs, co_sn;
  logic                               fin_valid;
  prap_pkg::prap_res_t                fin_res;

  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  prap_pkg::prap_res_t out_res_r, out_res_nxt;
  prap_pkg::prap_res_t skid_res_r, skid_res_nxt;
  logic                out_free;

  assign en = !skid_valid_r;

  prap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .pivot_x   (in_pivot_x),
    .pivot_y   (in_pivot_y),
    .angle_deg (in_angle_deg),
    .ctl_out   (fr_ctl),
    .geo_out   (fr_geo),
    .z_out     (fr_z)
  );

  prap_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (fr_ctl),
    .geo_in  (fr_geo),
    .z_in    (fr_z),
    .ctl_out (co_ctl),
    .geo_out (co_geo),
    .cs_out  (co_cs),
    .sn_out  (co_sn)
  );

  prap_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (co_ctl),
    .geo_in    (co_geo),
    .cs_in     (co_cs),
    .sn_in     (co_sn),
    .res_valid (fin_valid),
    .res       (fin_res)
  );

  // output register plus one skid entry; the pipeline only runs while the skid is empty
  always_comb begin
    out_free       = !out_valid_r || !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (out_free) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        out_res_nxt   = fin_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = fin_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign in_stall      = skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_rotated_x = out_res_r.rx;
  assign out_rotated_y = out_res_r.ry;
  assign out_saturated = out_res_r.sat;

endmodule

[hw/rtl/prap_front.sv]
// Front end: pivot differences, angle reduction modulo 360 and quadrant folding
`timescale 1ns / 1ps

module prap_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [prap_pkg::COORD_W-1:0]   point_x,
  input  logic signed [prap_pkg::COORD_W-1:0]   point_y,
  input  logic signed [prap_pkg::COORD_W-1:0]   pivot_x,
  input  logic signed [prap_pkg::COORD_W-1:0]   pivot_y,
  input  logic signed [prap_pkg::COORD_W-1:0]   angle_deg,
  output prap_pkg::prap_ctl_t                   ctl_out,
  output prap_pkg::prap_geo_t                   geo_out,
  output logic signed [prap_pkg::TURN_W-1:0]    z_out
);

  localparam int DEPTH = 7;

  logic [DEPTH-1:0]    vld_r;
  prap_pkg::prap_geo_t geo_r [DEPTH];
  prap_pkg::prap_geo_t geo_nxt;

  // stage a: offset angle to unsigned and add the period correction
  logic [prap_pkg::U_W-1:0]        a_u_r, a_u_nxt;
  // stage b: estimate of the high part divided by 45
  logic [prap_pkg::H_W-1:0]        b_h_r;
  logic [prap_pkg::LO_W-1:0]       b_lo_r;
  logic [prap_pkg::HQ_Q_W-1:0]     b_hq_r;
  logic [prap_pkg::HQ_P_W-1:0]     b_prod;
  // stage c: reduced angle r in [0, 360 << FRAC_BITS)
  logic [prap_pkg::H_W-1:0]        c_rem;
  logic [prap_pkg::HM_W:0]         c_rem7;
  logic [prap_pkg::HM_W-1:0]       c_hm;
  logic [prap_pkg::R_W-1:0]        c_r_r;
  // stage d: whole part and leftover of the turn scaling
  logic [prap_pkg::TP_W-1:0]       d_prod;
  logic [prap_pkg::TURN_W-1:0]     d_p_r;
  logic [prap_pkg::V_W-1:0]        d_v_r;
  // stage e: estimate of leftover / 45
  logic [prap_pkg::RQ_P_W-1:0]     e_prod;
  logic [prap_pkg::RQ_Q_W-1:0]     e_q_r;
  logic [prap_pkg::TURN_W-1:0]     e_p_r;
  logic [prap_pkg::V_W-1:0]        e_v_r;
  // stage f: turn fraction
  logic [prap_pkg::V_W-1:0]        f_rem;
  logic                            f_inc;
  logic [prap_pkg::TURN_W-1:0]     f_t_r;
  // stage g: folded angle
  logic signed [prap_pkg::TURN_W-1:0] g_ts;
  logic                               g_over;
  logic signed [prap_pkg::TURN_W-1:0] g_z_r;
  logic                               g_flip_r;

  always_comb begin
    geo_nxt.dx = prap_pkg::DIFF_W'(point_x) - prap_pkg::DIFF_W'(pivot_x);
    geo_nxt.dy = prap_pkg::DIFF_W'(point_y) - prap_pkg::DIFF_W'(pivot_y);
    geo_nxt.cx = pivot_x;
    geo_nxt.cy = pivot_y;
  end

  assign a_u_nxt = prap_pkg::U_W'({~angle_deg[prap_pkg::COORD_W-1],
                                   angle_deg[prap_pkg::COORD_W-2:0]})
                 + prap_pkg::U_W'(prap_pkg::ANG_ADD);

  assign b_prod = prap_pkg::HQ_P_W'(a_u_r[prap_pkg::U_W-1:prap_pkg::LO_W])
                * prap_pkg::HQ_P_W'(prap_pkg::HQ_M);

  // estimate is at most one low: one compare and subtract fixes it
  always_comb begin
    c_rem  = b_h_r - prap_pkg::H_W'(b_hq_r) * prap_pkg::H_W'(prap_pkg::DEG_DIV);
    c_rem7 = c_rem[prap_pkg::HM_W:0];
    if (c_rem7 >= (prap_pkg::HM_W+1)'(prap_pkg::DEG_DIV)) begin
      c_hm = prap_pkg::HM_W'(c_rem7 - (prap_pkg::HM_W+1)'(prap_pkg::DEG_DIV));
    end else begin
      c_hm = prap_pkg::HM_W'(c_rem7);
    end
  end

  assign d_prod = prap_pkg::TP_W'(c_r_r) * prap_pkg::TP_W'(prap_pkg::TQ);

  assign e_prod = prap_pkg::RQ_P_W'(d_v_r) * prap_pkg::RQ_P_W'(prap_pkg::RQ_M);

  always_comb begin
    f_rem = e_v_r - prap_pkg::V_W'(e_q_r) * prap_pkg::V_W'(prap_pkg::DEG_DIV);
    f_inc = (f_rem >= prap_pkg::V_W'(prap_pkg::DEG_DIV));
  end

  // beyond a quarter turn either way: move by a half turn and negate later
  always_comb begin
    g_ts   = f_t_r;
    g_over = (g_ts > prap_pkg::QUARTER) || (g_ts < -prap_pkg::QUARTER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[0] <= geo_nxt;
      for (int k = 1; k < DEPTH; k++) begin
        geo_r[k] <= geo_r[k-1];
      end
      a_u_r    <= a_u_nxt;
      b_h_r    <= a_u_r[prap_pkg::U_W-1:prap_pkg::LO_W];
      b_lo_r   <= a_u_r[prap_pkg::LO_W-1:0];
      b_hq_r   <= b_prod[prap_pkg::HQ_K +: prap_pkg::HQ_Q_W];
      c_r_r    <= {c_hm, b_lo_r};
      d_p_r    <= d_prod[prap_pkg::TURN_W-1:0];
      d_v_r    <= prap_pkg::V_W'(c_r_r) * prap_pkg::V_W'(prap_pkg::TR);
      e_q_r    <= e_prod[prap_pkg::RQ_K +: prap_pkg::RQ_Q_W];
      e_p_r    <= d_p_r;
      e_v_r    <= d_v_r;
      f_t_r    <= e_p_r + prap_pkg::TURN_W'(e_q_r) + prap_pkg::TURN_W'(f_inc);
      g_z_r    <= g_over ? {~f_t_r[prap_pkg::TURN_W-1], f_t_r[prap_pkg::TURN_W-2:0]}
                         : f_t_r;
      g_flip_r <= g_over;
    end
  end

  assign ctl_out.valid = vld_r[DEPTH-1];
  assign ctl_out.flip  = g_flip_r;
  assign geo_out       = geo_r[DEPTH-1];
  assign z_out         = g_z_r;

endmodule

[hw/rtl/prap_cordic.sv]
// CORDIC rotation pipeline: one micro-rotation per register stage
`timescale 1ns / 1ps

module prap_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  prap_pkg::prap_ctl_t                 ctl_in,
  input  prap_pkg::prap_geo_t                 geo_in,
  input  logic signed [prap_pkg::TURN_W-1:0]  z_in,
  output prap_pkg::prap_ctl_t                 ctl_out,
  output prap_pkg::prap_geo_t                 geo_out,
  output logic signed [prap_pkg::TRIG_W-1:0]  cs_out,
  output logic signed [prap_pkg::TRIG_W-1:0]  sn_out
);

  localparam int N = prap_pkg::CORDIC_STAGES;

  prap_pkg::prap_ctl_t                ctl_r [N];
  prap_pkg::prap_geo_t                geo_r [N];
  logic signed [prap_pkg::TRIG_W-1:0] cs_r  [N];
  logic signed [prap_pkg::TRIG_W-1:0] sn_r  [N];
  logic signed [prap_pkg::TURN_W-1:0] z_r   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    prap_pkg::prap_ctl_t                ctl_s;
    prap_pkg::prap_geo_t                geo_s;
    logic signed [prap_pkg::TRIG_W-1:0] cs_s, sn_s, xs, ys, cs_nxt, sn_nxt;
    logic signed [prap_pkg::TURN_W-1:0] z_s, z_nxt;

    if (i == 0) begin : g_first
      assign ctl_s = ctl_in;
      assign geo_s = geo_in;
      assign cs_s  = prap_pkg::INV_GAIN;
      assign sn_s  = '0;
      assign z_s   = z_in;
    end else begin : g_next
      assign ctl_s = ctl_r[i-1];
      assign geo_s = geo_r[i-1];
      assign cs_s  = cs_r[i-1];
      assign sn_s  = sn_r[i-1];
      assign z_s   = z_r[i-1];
    end

    // a zero residual angle rotates the positive way
    always_comb begin
      xs = cs_s >>> i;
      ys = sn_s >>> i;
      if (!z_s[prap_pkg::TURN_W-1]) begin
        cs_nxt = cs_s - ys;
        sn_nxt = sn_s + xs;
        z_nxt  = z_s - prap_pkg::atan_turn(5'(i));
      end else begin
        cs_nxt = cs_s + ys;
        sn_nxt = sn_s - xs;
        z_nxt  = z_s + prap_pkg::atan_turn(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        geo_r[i] <= geo_s;
        cs_r[i]  <= cs_nxt;
        sn_r[i]  <= sn_nxt;
        z_r[i]   <= z_nxt;
      end
    end
  end

  assign ctl_out = ctl_r[N-1];
  assign geo_out = geo_r[N-1];
  assign cs_out  = cs_r[N-1];
  assign sn_out  = sn_r[N-1];

endmodule

[hw/rtl/prap_mix.sv]
// Rotation of the pivot difference by cos/sin, rounding, pivot add-back and saturation
`timescale 1ns / 1ps

module prap_mix (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  prap_pkg::prap_ctl_t                 ctl_in,
  input  prap_pkg::prap_geo_t                 geo_in,
  input  logic signed [prap_pkg::TRIG_W-1:0]  cs_in,
  input  logic signed [prap_pkg::TRIG_W-1:0]  sn_in,
  output logic                                res_valid,
  output prap_pkg::prap_res_t                 res
);

  localparam int HI_W = prap_pkg::RND_W - prap_pkg::COORD_W + 1;
  localparam logic signed [prap_pkg::COORD_W-1:0] C_MAX =
    {1'b0, {(prap_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [prap_pkg::COORD_W-1:0] C_MIN =
    {1'b1, {(prap_pkg::COORD_W-1){1'b0}}};

  logic [2:0] vld_r;

  // m0: undo the half-turn fold
  logic signed [prap_pkg::TRIG_W-1:0]  m0_cs_r, m0_sn_r;
  prap_pkg::prap_geo_t                 m0_geo_r;
  // m1: four exact products
  logic signed [prap_pkg::PROD_W-1:0]  m1_xc_r, m1_ys_r, m1_xs_r, m1_yc_r;
  logic signed [prap_pkg::COORD_W-1:0] m1_cx_r, m1_cy_r;
  // m2: sums with the rounding half
  logic signed [prap_pkg::SUM_W-1:0]   m2_sx_r, m2_sy_r;
  logic signed [prap_pkg::COORD_W-1:0] m2_cx_r, m2_cy_r;

  logic signed [prap_pkg::RND_W-1:0]   rx_w, ry_w;
  logic [HI_W-1:0]                     rx_hi, ry_hi;
  logic                                sat_x, sat_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], ctl_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_cs_r  <= ctl_in.flip ? -cs_in : cs_in;
      m0_sn_r  <= ctl_in.flip ? -sn_in : sn_in;
      m0_geo_r <= geo_in;

      m1_xc_r  <= prap_pkg::PROD_W'(m0_geo_r.dx) * prap_pkg::PROD_W'(m0_cs_r);
      m1_ys_r  <= prap_pkg::PROD_W'(m0_geo_r.dy) * prap_pkg::PROD_W'(m0_sn_r);
      m1_xs_r  <= prap_pkg::PROD_W'(m0_geo_r.dx) * prap_pkg::PROD_W'(m0_sn_r);
      m1_yc_r  <= prap_pkg::PROD_W'(m0_geo_r.dy) * prap_pkg::PROD_W'(m0_cs_r);
      m1_cx_r  <= m0_geo_r.cx;
      m1_cy_r  <= m0_geo_r.cy;

      m2_sx_r  <= prap_pkg::SUM_W'(m1_xc_r) - prap_pkg::SUM_W'(m1_ys_r)
                + prap_pkg::RND_HALF;
      m2_sy_r  <= prap_pkg::SUM_W'(m1_xs_r) + prap_pkg::SUM_W'(m1_yc_r)
                + prap_pkg::RND_HALF;
      m2_cx_r  <= m1_cx_r;
      m2_cy_r  <= m1_cy_r;
    end
  end

  // floor shift, add the pivot back, clip on overflow
  always_comb begin
    rx_w  = prap_pkg::RND_W'(m2_sx_r >>> prap_pkg::TRIG_FRAC) + prap_pkg::RND_W'(m2_cx_r);
    ry_w  = prap_pkg::RND_W'(m2_sy_r >>> prap_pkg::TRIG_FRAC) + prap_pkg::RND_W'(m2_cy_r);
    rx_hi = rx_w[prap_pkg::RND_W-1:prap_pkg::COORD_W-1];
    ry_hi = ry_w[prap_pkg::RND_W-1:prap_pkg::COORD_W-1];
    sat_x = !((&rx_hi) || !(|rx_hi));
    sat_y = !((&ry_hi) || !(|ry_hi));
    if (sat_x) begin
      res.rx = rx_w[prap_pkg::RND_W-1] ? C_MIN : C_MAX;
    end else begin
      res.rx = rx_w[prap_pkg::COORD_W-1:0];
    end
    if (sat_y) begin
      res.ry = ry_w[prap_pkg::RND_W-1] ? C_MIN : C_MAX;
    end else begin
      res.ry = ry_w[prap_pkg::COORD_W-1:0];
    end
    res.sat = sat_x || sat_y;
  end

  assign res_valid = vld_r[2];

endmodule

[hw/rtl/prap_checker.sv]
// Port-level checks for the point rotation core, bound to the top level
`timescale 1ns / 1ps
`include "point_rotate_about_pivot_core_defines.svh"

module prap_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [prap_pkg::COORD_W-1:0] out_rotated_x,
  input logic signed [prap_pkg::COORD_W-1:0] out_rotated_y,
  input logic                                out_saturated
);

  localparam logic signed [prap_pkg::COORD_W-1:0] C_MAX =
    {1'b0, {(prap_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [prap_pkg::COORD_W-1:0] C_MIN =
    {1'b1, {(prap_pkg::COORD_W-1){1'b0}}};

  `PRAP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  `PRAP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_rotated_x) && $stable(out_rotated_y) && $stable(out_saturated), "stalled result changed")

  `PRAP_ASSERT_IMP(a_sat_clip, out_valid && out_saturated, out_rotated_x == C_MAX || out_rotated_x == C_MIN || out_rotated_y == C_MAX || out_rotated_y == C_MIN, "saturated flag without a clipped coordinate")

  `PRAP_ASSERT_IMP(a_in_stall_cause, in_stall, $past(out_valid && out_stall), "input stalled without a held result")

endmodule

bind point_rotate_about_pivot_core prap_checker u_prap_checker (.*);

[tb/sv/point_rotate_about_pivot_core_tb.sv]
// Self-checking testbench for the point rotation core
`timescale 1ns / 1ps

module point_rotate_about_pivot_core_tb;

  localparam int W = prap_pkg::COORD_W;

  // Q15.16 helpers for building stimulus
  localparam int ONE      = 65536;
  localparam int DEG      = 65536;
  localparam int MAX_C    = 32'sh7fffffff;
  localparam int MIN_C    = 32'sh80000000;
  localparam int SPAN     = 1000 * ONE;
  localparam int RANDOM_JOBS = 1880;

  // Angle arithmetic: degrees to a 32-bit turn fraction
  localparam int     FRAC          = 16;
  localparam int     TURN_BITS     = 32;
  localparam int     ROT_FRAC      = 30;
  localparam int     ROT_STAGES    = 16;
  localparam longint DEG_PER_TURN  = 360;
  localparam longint TURN_PERIOD   = DEG_PER_TURN << FRAC;
  localparam longint FULL_TURN     = longint'(1) << TURN_BITS;
  localparam longint HALF_TURN     = longint'(1) << (TURN_BITS - 1);
  localparam longint QUARTER_TURN  = longint'(1) << (TURN_BITS - 2);
  // 1/K of the rotation stages in Q1.30, truncated
  localparam longint GAIN_COMP     = 64'd652032874;
  localparam logic signed [95:0] ROUND_HALF = 96'sd536870912;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 300;
  localparam int STEADY_LO   = 1000;
  localparam int STEADY_HI   = 1400;
  localparam int DRAIN       = 40;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] pivot_x;
    logic signed [W-1:0] pivot_y;
    logic signed [W-1:0] angle_deg;
  } rot_job_t;

  typedef struct packed {
    logic signed [W-1:0] rx;
    logic signed [W-1:0] ry;
    logic                sat;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] in_point_x = '0;
  logic signed [W-1:0] in_point_y = '0;
  logic signed [W-1:0] in_pivot_x = '0;
  logic signed [W-1:0] in_pivot_y = '0;
  logic signed [W-1:0] in_angle_deg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_rotated_x;
  logic signed [W-1:0] out_rotated_y;
  logic out_saturated;

  rot_job_t    jobs_to_send[$];
  rot_result_t rotations_due[$];
  rot_job_t    cur_job;

  int total_jobs;
  int directed_jobs;
  int sent_count;
  int got_count;
  int sat_count;
  int input_stalls;
  int errors;
  int cycle_count;
  int hold_left;
  bit hold_done;

  point_rotate_about_pivot_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_pivot_x   (in_pivot_x),
    .in_pivot_y   (in_pivot_y),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  function automatic logic signed [W-1:0] clip_coord(input longint v, output bit clipped);
    longint hi;
    longint lo;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    clipped = 1'b0;
    if (v > hi) begin
      v = hi;
      clipped = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      clipped = 1'b1;
    end
    return v[W-1:0];
  endfunction

  // Subtract the pivot, rotate by the CORDIC sine/cosine, round, add the pivot back and clip
  function automatic rot_result_t rotate_about_pivot(input rot_job_t job);
    rot_result_t res;
    longint r, z, cs, sn, xs, ys, step, dx, dy, rx, ry;
    logic signed [95:0] dxw, dyw, csw, snw, acc;
    bit flip, x_clip, y_clip;
    int k;
    r = longint'(job.angle_deg) % TURN_PERIOD;
    if (r < 0) r += TURN_PERIOD;
    z = (r << (TURN_BITS - FRAC)) / DEG_PER_TURN;
    if (z >= HALF_TURN) z -= FULL_TURN;
    // fold into the right half plane, negate sine and cosine afterwards
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      flip = 1'b1;
    end
    cs = GAIN_COMP;
    sn = 0;
    for (k = 0; k < ROT_STAGES; k++) begin
      case (k)
        0:  step = 536870912;
        1:  step = 316933406;
        2:  step = 167458907;
        3:  step = 85004756;
        4:  step = 42667331;
        5:  step = 21354465;
        6:  step = 10679838;
        7:  step = 5340245;
        8:  step = 2670163;
        9:  step = 1335087;
        10: step = 667544;
        11: step = 333772;
        12: step = 166886;
        13: step = 83443;
        14: step = 41722;
        15: step = 20861;
        default: step = 0;
      endcase
      xs = cs >>> k;
      ys = sn >>> k;
      if (z >= 0) begin
        cs -= ys;
        sn += xs;
        z  -= step;
      end else begin
        cs += ys;
        sn -= xs;
        z  += step;
      end
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    dx  = longint'(job.point_x) - longint'(job.pivot_x);
    dy  = longint'(job.point_y) - longint'(job.pivot_y);
    dxw = dx;
    dyw = dy;
    csw = cs;
    snw = sn;
    acc = dxw * csw - dyw * snw + ROUND_HALF;
    rx  = longint'(acc >>> ROT_FRAC) + longint'(job.pivot_x);
    acc = dxw * snw + dyw * csw + ROUND_HALF;
    ry  = longint'(acc >>> ROT_FRAC) + longint'(job.pivot_y);
    res.rx  = clip_coord(rx, x_clip);
    res.ry  = clip_coord(ry, y_clip);
    res.sat = x_clip | y_clip;
    return res;
  endfunction

  task automatic queue_job(input int px, input int py, input int cx, input int cy,
                           input int ang);
    rot_job_t job;
    job.point_x   = px;
    job.point_y   = py;
    job.pivot_x   = cx;
    job.pivot_y   = cy;
    job.angle_deg = ang;
    jobs_to_send.push_back(job);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(2 * SPAN)) - SPAN;
      2: return int'($urandom) >>> 12;
      default: begin
        case ($urandom_range(3))
          0: return MAX_C;
          1: return MIN_C;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Driver: offer queued points, predict each one on transfer
  always @(posedge clk) begin : drive_points
    rot_job_t job;
    bit steady;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rotations_due.push_back(rotate_about_pivot(cur_job));
        sent_count++;
      end else if (in_valid) begin
        input_stalls++;
      end
      steady = (sent_count >= STEADY_LO) && (sent_count < STEADY_HI);
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (jobs_to_send.size() > 0 && (steady || $urandom_range(99) >= 11)) begin
          job = jobs_to_send.pop_front();
          cur_job      <= job;
          in_point_x   <= job.point_x;
          in_point_y   <= job.point_y;
          in_pivot_x   <= job.pivot_x;
          in_pivot_y   <= job.pivot_y;
          in_angle_deg <= job.angle_deg;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then decide the next cycle's stall
  always @(posedge clk) begin : check_results
    rot_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_count++;
        if (out_saturated) sat_count++;
        if (rotations_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time,
                     out_rotated_x, out_rotated_y, out_saturated);
        end else begin
          want = rotations_due.pop_front();
          if (out_rotated_x !== want.rx) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: rotated_x expected %0d got %0d", $time, want.rx, out_rotated_x);
          end
          if (out_rotated_y !== want.ry) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: rotated_y expected %0d got %0d", $time, want.ry, out_rotated_y);
          end
          if (out_saturated !== want.sat) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: saturated expected %0b got %0b", $time, want.sat, out_saturated);
          end
        end
      end
      // one long hold so the pipeline backs up into the input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && got_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(got_count >= STEADY_LO && got_count < STEADY_HI) &&
                     ($urandom_range(99) < 11);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles: %0d of %0d points sent, %0d results outstanding",
               cycle_count, sent_count, total_jobs, rotations_due.size());
      $display("point_rotate_about_pivot_core test failed");
      $finish;
    end
  end

  initial begin : run_test
    int px, py, cx, cy, ang;
    int n;

    queue_job(0, 0, 0, 0, 0);
    queue_job(ONE, 0, 0, 0, 90 * DEG);
    queue_job(ONE, ONE, 0, 0, 45 * DEG);
    queue_job(3 * ONE, ONE, ONE, ONE, 180 * DEG);
    queue_job(ONE, 0, 0, 0, 270 * DEG);
    queue_job(ONE, 0, 0, 0, -90 * DEG);
    queue_job(2 * ONE, -ONE, -ONE, 5 * ONE, 360 * DEG);
    // just past a quarter turn: folds into the other half plane
    queue_job(ONE, 0, 0, 0, 90 * DEG + 1);
    queue_job(ONE, ONE, 0, 0, MAX_C);
    queue_job(ONE, ONE, 0, 0, MIN_C);
    queue_job(ONE, ONE, 0, 0, -1);
    queue_job(ONE, 0, 0, 0, 1);
    // out of range in both directions
    queue_job(MAX_C, MAX_C, MIN_C, MIN_C, 0);
    queue_job(MIN_C, MIN_C, MAX_C, MAX_C, 0);
    queue_job(MAX_C, 0, MIN_C, 0, 180 * DEG);
    queue_job(MAX_C, MAX_C, 0, 0, 45 * DEG);
    // point on the pivot stays put
    queue_job(MIN_C, MAX_C, MIN_C, MAX_C, 123 * DEG);
    queue_job(-1, -1, 0, 0, 179 * DEG);
    queue_job(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'h5a5a5a5a);
    queue_job(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 32'ha5a5a5a5);
    queue_job(1000 * ONE, -1000 * ONE, 0, 0, 720 * DEG + DEG / 2);
    queue_job(0, MAX_C, 0, 0, -3600 * DEG);
    directed_jobs = jobs_to_send.size();

    for (n = 0; n < RANDOM_JOBS; n++) begin
      px = rand_coord();
      py = rand_coord();
      if ($urandom_range(3) == 0) begin
        cx = 0;
        cy = 0;
      end else begin
        cx = rand_coord();
        cy = rand_coord();
      end
      case ($urandom_range(3))
        0: ang = $urandom;
        1: ang = (int'($urandom_range(16)) - 8) * 90 * DEG + int'($urandom_range(2)) - 1;
        2: ang = int'($urandom_range(2 * 720 * DEG)) - 720 * DEG;
        default: ang = int'($urandom_range(360 * DEG - 1));
      endcase
      queue_job(px, py, cx, cy, ang);
    end
    total_jobs = jobs_to_send.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_jobs || rotations_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Rotated %0d points (%0d directed) about origin and arbitrary pivots;",
             sent_count, directed_jobs);
    $display("%0d results checked, %0d saturated, input held off for %0d cycles.",
             got_count, sat_count, input_stalls);
    if (errors == 0 && rotations_due.size() == 0) begin
      $display("point_rotate_about_pivot_core test passed");
    end else begin
      $display("point_rotate_about_pivot_core test failed");
    end
    $finish;
  end

endmodule
